### src/fmv_pkg.sv
// Shared types and constants for the dual-policy waiting pool.
// No dependencies; imported by the controller, the datapath and the top level.
package fmv_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 2;
    localparam int DATA_W       = 32;
    localparam int ID_W         = 32;
    localparam int STATUS_W     = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_OLDEST = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_SERVED    = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_EXHAUSTED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INS_SCAN,
        S_SRV_SCAN,
        S_SRV_LAST,
        S_SRV_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    clr_idx;
        logic    inc_idx;
        logic    ins_commit;
        logic    srv_read;
        logic    srv_commit;
        logic    emit;
        t_status emit_status;
    } t_cmd;

    typedef struct packed {
        logic is_insert;
        logic exhausted;
        logic full;
        logic empty;
        logic slot_free;
        logic idx_last;
    } t_sts;

endpackage

### src/fmv_datapath.sv
// Datapath: slot memories, valid bits, arrival counter, scan compare, result register.
// Depends on fmv_pkg; driven by fmv_ctrl through t_cmd, reports through t_sts.
module fmv_datapath
    import fmv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_result_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_entry_id
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic signed [DATA_W-1:0] r_mem_value [CAPACITY];
    logic        [ID_W-1:0]   r_mem_id    [CAPACITY];
    logic [CAPACITY-1:0]      r_valid;

    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [ID_W-1:0]          r_next_id;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;

    logic                     r_rd_act;
    logic                     r_rd_vld;
    logic [IDX_W-1:0]         r_rd_slot;
    logic signed [DATA_W-1:0] r_rd_value;
    logic [ID_W-1:0]          r_rd_id;

    logic                     r_have;
    logic [IDX_W-1:0]         r_best_slot;
    logic signed [DATA_W-1:0] r_best_value;
    logic [ID_W-1:0]          r_best_id;

    logic                     r_result_valid;
    t_status                  r_status;
    logic [ID_W-1:0]          r_entry_id;

    logic better;
    logic take;

    // Memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_commit) begin
            r_mem_value[r_idx] <= r_value;
            r_mem_id[r_idx]    <= r_next_id;
        end
        r_rd_value <= r_mem_value[r_idx];
        r_rd_id    <= r_mem_id[r_idx];
        r_rd_vld   <= r_valid[r_idx];
        r_rd_slot  <= r_idx;
    end

    always_comb begin
        if (r_op == OP_OLDEST) begin
            better = r_rd_id < r_best_id;
        end else begin
            better = (r_rd_value > r_best_value) ||
                     ((r_rd_value == r_best_value) && (r_rd_id < r_best_id));
        end
        take = r_rd_act && r_rd_vld && (!r_have || better);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_value <= i_item_value;
        end
        if (take) begin
            r_best_slot  <= r_rd_slot;
            r_best_value <= r_rd_value;
            r_best_id    <= r_rd_id;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            unique case (i_cmd.emit_status)
                ST_INSERTED: r_entry_id <= r_next_id;
                ST_SERVED:   r_entry_id <= r_best_id;
                default:     r_entry_id <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_next_id      <= ID_W'(1);
            r_count        <= '0;
            r_idx          <= '0;
            r_rd_act       <= 1'b0;
            r_have         <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_rd_act       <= i_cmd.srv_read;
            r_result_valid <= i_cmd.emit;
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
            if (i_cmd.ins_commit) begin
                r_valid[r_idx] <= 1'b1;
                r_next_id      <= r_next_id + 1'b1;
                r_count        <= r_count + 1'b1;
            end else if (i_cmd.srv_commit) begin
                r_valid[r_best_slot] <= 1'b0;
                r_count              <= r_count - 1'b1;
            end
        end
    end

    assign o_sts.is_insert = (r_op == OP_INSERT);
    assign o_sts.exhausted = (r_next_id == '1);
    assign o_sts.full      = (r_count == CNT_FULL);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.slot_free = !r_valid[r_idx];
    assign o_sts.idx_last  = (r_idx == IDX_LAST);

    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_entry_id     = r_entry_id;

endmodule

### src/fmv_ctrl.sv
// Controller state machine: sequences checks, the free-slot scan and the serve scan.
// Depends on fmv_pkg; drives fmv_datapath through t_cmd and reads t_sts.
module fmv_ctrl
    import fmv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.emit_status = ST_EMPTY;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.clr_idx = 1'b1;
                if (i_sts.is_insert) begin
                    // exhausted id check takes priority over the full check
                    priority if (i_sts.exhausted) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_EXHAUSTED;
                        n_state           = S_IDLE;
                    end else if (i_sts.full) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_FULL;
                        n_state           = S_IDLE;
                    end else begin
                        n_state = S_INS_SCAN;
                    end
                end else if (i_sts.empty) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_EMPTY;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_SRV_SCAN;
                end
            end
            S_INS_SCAN: begin
                if (i_sts.slot_free) begin
                    o_cmd.ins_commit  = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_INSERTED;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_SRV_SCAN: begin
                o_cmd.srv_read = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_SRV_LAST;
                end
            end
            S_SRV_LAST: begin
                // let the last slot read reach the compare
                n_state = S_SRV_DONE;
            end
            S_SRV_DONE: begin
                o_cmd.srv_commit  = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = ST_SERVED;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### src/fifo_and_max_value_server.sv
// Dual-policy waiting pool: serve oldest entry or entry with the largest value.
// Usage:
//   Command channel: raise start with i_opcode and i_item_value; a transfer
//   happens at a rising edge where start is high and busy is low.
//   Opcode insert stores the value under the next arrival number (from 1);
//   serve-oldest and serve-largest remove and report one waiting entry.
//   Result channel: o_result_valid is high for exactly one cycle with
//   o_status and o_entry_id; the receiver cannot stall it.
// Operation (one command at a time, busy high while working):
//   refused insert or serve on empty pool: result decided in the check state;
//   insert: scans upward from slot 0 and stores in the lowest free slot;
//   serve: scans every slot, one slot per cycle, through
//   the single read port of the slot memories.
//   A new command may be given in the cycle the result strobe is high.
// Reset (i_rst_n low, synchronous): pool empty, next arrival number 1,
//   no result pending. Slot memories are not cleared; valid bits guard them.
// Built from: fmv_pkg, fmv_ctrl, fmv_datapath.
module fifo_and_max_value_server
    import fmv_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_result_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_entry_id
);

    t_cmd cmd;
    t_sts sts;

    fmv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fmv_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_opcode),
        .i_item_value   (i_item_value),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_entry_id     (o_entry_id)
    );

endmodule
